FILE: hw/rtl/sfr_pkg.sv
`timescale 1ns / 1ps

package sfr_pkg;

    localparam int PATTERN_MAX_DEF = 8;
    localparam int REPLACE_MAX     = 8;
    localparam int CFG_W           = 64;
    localparam int LEN_W           = 4;
    localparam int Q_DEPTH         = 2;

    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

    typedef enum logic [1:0] {
        CFG_PATTERN_BYTES      = 2'd0,
        CFG_PATTERN_LENGTH     = 2'd1,
        CFG_REPLACEMENT_BYTES  = 2'd2,
        CFG_REPLACEMENT_LENGTH = 2'd3
    } cfg_addr_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_NL,
        ST_REPL,
        ST_FINISH
    } state_t;

    // one request as classified by the front
    typedef struct packed {
        logic [7:0] data;
        logic       nl;
        logic       eos;
    } q_item_t;

    // effective lengths after clamping
    typedef struct packed {
        logic [LEN_W-1:0] plen;
        logic [LEN_W-1:0] rlen;
    } len_t;

endpackage

FILE: hw/rtl/stream_find_and_replace.sv
`timescale 1ns / 1ps

// Streaming find-and-replace over a byte stream: every leftmost, non-overlapping
// occurrence of the programmed pattern (1 to PATTERN_MAX bytes) is replaced by the
// programmed replacement (0 to 8 bytes); matches never cross a newline and the
// request that carries tlast flushes all held bytes. A front stage classifies each
// request into a two-entry queue and a single scan engine works one request at a
// time, producing at most one result per cycle. For each request the engine takes it
// from the queue, sends out the held bytes that can no longer start a match, then a
// newline or the replacement where one is due, and closes the request; a byte that
// passes straight through is sent out, and a request that is only held sends nothing.
// Results leave through a one-deep hold stage and an output register; a low
// m_tready stalls the engine once both are full. The last result of each request
// has m_tlast set. Program the registers only while the block is idle.
module stream_find_and_replace
#(
    parameter int PATTERN_MAX = sfr_pkg::PATTERN_MAX_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // in_byte
    input  logic                       s_tlast,   // end_of_stream
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata,   // out_byte
    output logic                       m_tlast,   // run_last
    output logic [1:0]                 m_tuser,   // byte_valid, stream_done
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_addr,
    input  logic [sfr_pkg::CFG_W-1:0]  cfg_data
);

    localparam int LEN_W = sfr_pkg::LEN_W;

    logic [8*PATTERN_MAX-1:0]    pattern_reg;
    logic [LEN_W-1:0]            plen_reg;
    logic [sfr_pkg::CFG_W-1:0]   replacement_reg;
    logic [LEN_W-1:0]            rlen_reg;
    sfr_pkg::len_t               lens;

    logic                        q_full;
    logic                        q_push;
    sfr_pkg::q_item_t            push_item;
    logic                        q_empty;
    logic                        q_pop;
    sfr_pkg::q_item_t            pop_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg     <= '0;
            plen_reg        <= LEN_W'(1);
            replacement_reg <= '0;
            rlen_reg        <= '0;
        end
        else if (cfg_we)
        begin
            unique case (sfr_pkg::cfg_addr_t'(cfg_addr))
                sfr_pkg::CFG_PATTERN_BYTES:      pattern_reg     <= cfg_data[8*PATTERN_MAX-1:0];
                sfr_pkg::CFG_PATTERN_LENGTH:     plen_reg        <= cfg_data[LEN_W-1:0];
                sfr_pkg::CFG_REPLACEMENT_BYTES:  replacement_reg <= cfg_data;
                sfr_pkg::CFG_REPLACEMENT_LENGTH: rlen_reg        <= cfg_data[LEN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // clamp lengths to the supported range
    always_comb
    begin
        if (plen_reg == '0)
        begin
            lens.plen = LEN_W'(1);
        end
        else if (plen_reg > LEN_W'(PATTERN_MAX))
        begin
            lens.plen = LEN_W'(PATTERN_MAX);
        end
        else
        begin
            lens.plen = plen_reg;
        end
        if (rlen_reg > LEN_W'(sfr_pkg::REPLACE_MAX))
        begin
            lens.rlen = LEN_W'(sfr_pkg::REPLACE_MAX);
        end
        else
        begin
            lens.rlen = rlen_reg;
        end
    end

    sfr_front u_front
    (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    sfr_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .empty     (q_empty)
    );

    sfr_back
    #(
        .PATTERN_MAX (PATTERN_MAX)
    )
    u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_item      (pop_item),
        .q_pop       (q_pop),
        .pattern     (pattern_reg),
        .replacement (replacement_reg),
        .lens        (lens),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

endmodule

FILE: hw/rtl/sfr_front.sv
`timescale 1ns / 1ps

module sfr_front
(
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,
    input  logic              s_tlast,
    input  logic              q_full,
    output logic              q_push,
    output sfr_pkg::q_item_t  q_item
);

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb
    begin
        q_item.data = s_tdata;
        q_item.nl   = (s_tdata == sfr_pkg::NEWLINE_BYTE);
        q_item.eos  = s_tlast;
    end

endmodule

FILE: hw/rtl/sfr_fifo.sv
`timescale 1ns / 1ps

module sfr_fifo
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sfr_pkg::q_item_t  push_item,
    output logic              full,
    input  logic              pop,
    output sfr_pkg::q_item_t  pop_item,
    output logic              empty
);

    localparam int PTR_W = (sfr_pkg::Q_DEPTH > 1) ? $clog2(sfr_pkg::Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(sfr_pkg::Q_DEPTH + 1);

    sfr_pkg::q_item_t   mem_reg [sfr_pkg::Q_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign full     = (count_reg == CNT_W'(sfr_pkg::Q_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = mem_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(sfr_pkg::Q_DEPTH - 1))
        begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: hw/rtl/sfr_back.sv
`timescale 1ns / 1ps

module sfr_back
#(
    parameter int PATTERN_MAX = sfr_pkg::PATTERN_MAX_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_empty,
    input  sfr_pkg::q_item_t           q_item,
    output logic                       q_pop,
    input  logic [8*PATTERN_MAX-1:0]   pattern,
    input  logic [sfr_pkg::CFG_W-1:0]  replacement,
    input  sfr_pkg::len_t              lens,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata,   // out_byte
    output logic                       m_tlast,   // run_last
    output logic [1:0]                 m_tuser    // byte_valid, stream_done
);

    localparam int BUF_W = 8 * PATTERN_MAX;
    localparam int CNT_W = $clog2(PATTERN_MAX + 1);
    localparam int LEN_W = sfr_pkg::LEN_W;

    sfr_pkg::state_t    state_reg;
    sfr_pkg::state_t    state_next;
    logic [BUF_W-1:0]   buf_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               eos_reg;
    logic               nl_reg;
    logic [LEN_W-1:0]   rep_idx_reg;
    logic [7:0]         hold_reg;
    logic               hold_valid_reg;
    logic               out_valid_reg;
    logic [7:0]         out_byte_reg;
    logic               out_bv_reg;
    logic               out_last_reg;
    logic               out_done_reg;

    logic [BUF_W-1:0]   append_buf;
    logic [BUF_W-1:0]   diff;
    logic               bytes_match;
    logic               prefix;
    logic               scan_term;
    logic               scan_take;
    logic               emit_want;
    logic [7:0]         emit_byte;
    logic               do_shift;
    logic               do_take;
    logic               fin_want;
    logic               slot_ok;
    logic               push_ok;
    logic               fin_ok;
    logic               emit_fire;
    logic               fin_fire;
    logic               out_load;

    // prefix test of held bytes against the pattern
    assign diff = buf_reg ^ pattern;

    always_comb
    begin
        bytes_match = 1'b1;
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            if ((CNT_W'(k) < cnt_reg) && (diff[8*k +: 8] != 8'h00))
            begin
                bytes_match = 1'b0;
            end
        end
    end

    assign prefix    = (LEN_W'(cnt_reg) <= lens.plen) && bytes_match;
    assign scan_term = (cnt_reg == '0) || (prefix && (LEN_W'(cnt_reg) < lens.plen));
    assign scan_take = prefix && !hold_valid_reg;

    always_comb
    begin
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            if (CNT_W'(k) == cnt_reg)
            begin
                append_buf[8*k +: 8] = q_item.data;
            end
            else if (CNT_W'(k) < cnt_reg)
            begin
                append_buf[8*k +: 8] = buf_reg[8*k +: 8];
            end
            else
            begin
                append_buf[8*k +: 8] = 8'h00;
            end
        end
    end

    // handshake toward the output register and the one-deep hold stage
    assign slot_ok   = !out_valid_reg || m_tready;
    assign push_ok   = !hold_valid_reg || slot_ok;
    assign fin_ok    = slot_ok || (!hold_valid_reg && !eos_reg);
    assign emit_fire = emit_want && push_ok;
    assign fin_fire  = fin_want && fin_ok;
    assign out_load  = (emit_fire && hold_valid_reg) ||
                       (fin_fire && (hold_valid_reg || eos_reg));

    always_comb
    begin
        q_pop     = 1'b0;
        emit_want = 1'b0;
        emit_byte = 8'h00;
        do_shift  = 1'b0;
        do_take   = 1'b0;
        fin_want  = 1'b0;
        unique case (state_reg)
            sfr_pkg::ST_IDLE:
            begin
                q_pop = !q_empty;
            end
            sfr_pkg::ST_SCAN:
            begin
                if (scan_term)
                begin
                    fin_want = !eos_reg;
                end
                else if (scan_take)
                begin
                    do_take = 1'b1;
                end
                else
                begin
                    emit_want = 1'b1;
                    emit_byte = buf_reg[7:0];
                    do_shift  = 1'b1;
                end
            end
            sfr_pkg::ST_FLUSH:
            begin
                if (cnt_reg != '0)
                begin
                    emit_want = 1'b1;
                    emit_byte = buf_reg[7:0];
                    do_shift  = 1'b1;
                end
            end
            sfr_pkg::ST_NL:
            begin
                emit_want = 1'b1;
                emit_byte = sfr_pkg::NEWLINE_BYTE;
            end
            sfr_pkg::ST_REPL:
            begin
                if (rep_idx_reg < lens.rlen)
                begin
                    emit_want = 1'b1;
                    emit_byte = replacement[{rep_idx_reg[2:0], 3'b000} +: 8];
                end
            end
            sfr_pkg::ST_FINISH:
            begin
                fin_want = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sfr_pkg::ST_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = q_item.nl ? sfr_pkg::ST_FLUSH : sfr_pkg::ST_SCAN;
                end
            end
            sfr_pkg::ST_SCAN:
            begin
                if (scan_term)
                begin
                    if (eos_reg)
                    begin
                        state_next = sfr_pkg::ST_FLUSH;
                    end
                    else if (fin_fire)
                    begin
                        state_next = sfr_pkg::ST_IDLE;
                    end
                end
                else if (scan_take)
                begin
                    state_next = sfr_pkg::ST_REPL;
                end
            end
            sfr_pkg::ST_FLUSH:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = nl_reg ? sfr_pkg::ST_NL : sfr_pkg::ST_FINISH;
                end
            end
            sfr_pkg::ST_NL:
            begin
                if (emit_fire)
                begin
                    state_next = sfr_pkg::ST_FINISH;
                end
            end
            sfr_pkg::ST_REPL:
            begin
                if (rep_idx_reg >= lens.rlen)
                begin
                    state_next = sfr_pkg::ST_FINISH;
                end
            end
            sfr_pkg::ST_FINISH:
            begin
                if (fin_fire)
                begin
                    state_next = sfr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sfr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sfr_pkg::ST_IDLE;
            cnt_reg        <= '0;
            eos_reg        <= 1'b0;
            nl_reg         <= 1'b0;
            rep_idx_reg    <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop)
            begin
                eos_reg <= q_item.eos;
                nl_reg  <= q_item.nl;
                if (!q_item.nl)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            if (do_take)
            begin
                cnt_reg     <= '0;
                rep_idx_reg <= '0;
            end
            if (do_shift && emit_fire)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            if ((state_reg == sfr_pkg::ST_REPL) && emit_fire)
            begin
                rep_idx_reg <= rep_idx_reg + 1'b1;
            end
            if (emit_fire)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (fin_fire)
            begin
                hold_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && !q_item.nl)
        begin
            buf_reg <= append_buf;
        end
        else if (do_take)
        begin
            buf_reg <= '0;
        end
        else if (do_shift && emit_fire)
        begin
            buf_reg <= buf_reg >> 8;
        end
        if (emit_fire)
        begin
            hold_reg <= emit_byte;
        end
        if (out_load)
        begin
            if (emit_fire)
            begin
                out_byte_reg <= hold_reg;
                out_bv_reg   <= 1'b1;
                out_last_reg <= 1'b0;
                out_done_reg <= 1'b0;
            end
            else
            begin
                out_byte_reg <= hold_valid_reg ? hold_reg : 8'h00;
                out_bv_reg   <= hold_valid_reg;
                out_last_reg <= 1'b1;
                out_done_reg <= eos_reg;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_done_reg, out_bv_reg};

    a_idle_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sfr_pkg::ST_IDLE) |-> !hold_valid_reg)
        else $error("result left in hold stage between requests");

    a_repl_empty_buf: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sfr_pkg::ST_REPL) |-> (cnt_reg == '0))
        else $error("held bytes remain during replacement");

    a_emit_holds: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire |=> hold_valid_reg)
        else $error("emitted byte not captured");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || m_tready))
        else $error("output register overwritten while stalled");

endmodule

FILE: dv/stream_find_and_replace_tb.sv
`timescale 1ns / 1ps

module stream_find_and_replace_tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_WAIT  = 24;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 40;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
        logic       done;
    } edit_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [7:0]                s_tdata = '0;    // in_byte
    logic                      s_tlast = 1'b0;  // end_of_stream
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [7:0]                m_tdata;         // out_byte
    logic                      m_tlast;         // run_last
    logic [1:0]                m_tuser;         // byte_valid, stream_done
    logic                      cfg_we = 1'b0;
    logic [1:0]                cfg_addr = '0;
    logic [sfr_pkg::CFG_W-1:0] cfg_data = '0;

    // mirror of the programmed registers and the held text
    logic [63:0] pat_bytes  = '0;
    logic [3:0]  pat_len    = 4'd1;
    logic [63:0] rep_bytes  = '0;
    logic [3:0]  rep_len    = 4'd0;
    logic [63:0] held_bytes = '0;
    int          held_count = 0;

    edit_t edits_due[$];
    edit_t got;
    edit_t want;

    int  items_sent  = 0;
    int  results_seen = 0;
    int  cfg_writes  = 0;
    int  errors      = 0;
    int  cycles      = 0;
    int  hold_req    = 0;
    int  hold_left   = 0;
    int  gap_left    = 0;
    bit  tx_stall    = 1'b1;
    bit  rx_stall    = 1'b1;

    stream_find_and_replace dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [63:0] byte_mask(input int n);
        if (n >= 8)
            return '1;
        return (64'd1 << (8 * n)) - 64'd1;
    endfunction

    function automatic int eff_plen();
        if (pat_len == 0)
            return 1;
        if (pat_len > 8)
            return 8;
        return int'(pat_len);
    endfunction

    function automatic void predict_edit(input logic [7:0] b, input logic eos);
        logic [7:0]  emit [8];
        logic [63:0] text;
        int          n;
        int          cnt;
        int          plen;
        int          rlen;
        int          i;
        bit          is_prefix;
        edit_t       e;
        n    = 0;
        text = held_bytes;
        cnt  = held_count;
        plen = eff_plen();
        rlen = (rep_len > 8) ? 8 : int'(rep_len);
        if (b == sfr_pkg::NEWLINE_BYTE)
        begin
            for (i = 0; i < cnt && n < 8; i++)
            begin
                emit[n] = text[8*i +: 8];
                n++;
            end
            if (n < 8)
            begin
                emit[n] = b;
                n++;
            end
            text = '0;
            cnt  = 0;
        end
        else
        begin
            text = (text & byte_mask(cnt)) | (64'(b) << (8 * cnt));
            cnt++;
            while (cnt > 0)
            begin
                is_prefix = cnt <= plen && ((text ^ pat_bytes) & byte_mask(cnt)) == 64'd0;
                if (is_prefix && cnt < plen)
                    break;
                // a full match only counts when nothing went out earlier in this step
                if (is_prefix && n == 0)
                begin
                    for (i = 0; i < rlen && n < 8; i++)
                    begin
                        emit[n] = rep_bytes[8*i +: 8];
                        n++;
                    end
                    text = '0;
                    cnt  = 0;
                    break;
                end
                if (n < 8)
                begin
                    emit[n] = text[7:0];
                    n++;
                end
                text = text >> 8;
                cnt--;
            end
        end
        if (eos)
        begin
            for (i = 0; i < cnt && n < 8; i++)
            begin
                emit[n] = text[8*i +: 8];
                n++;
            end
            text = '0;
            cnt  = 0;
        end
        held_bytes = text & byte_mask(cnt);
        held_count = cnt;
        if (n == 0 && eos)
        begin
            e = '{8'h00, 1'b0, 1'b1, 1'b1};
            edits_due.push_back(e);
        end
        for (i = 0; i < n; i++)
        begin
            e = '{emit[i], 1'b1, i == n - 1, (i == n - 1) && eos};
            edits_due.push_back(e);
        end
    endfunction

    task automatic cfg_write(input sfr_pkg::cfg_addr_t idx, input logic [63:0] value);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            sfr_pkg::CFG_PATTERN_BYTES:      pat_bytes = value;
            sfr_pkg::CFG_PATTERN_LENGTH:     pat_len   = value[3:0];
            sfr_pkg::CFG_REPLACEMENT_BYTES:  rep_bytes = value;
            sfr_pkg::CFG_REPLACEMENT_LENGTH: rep_len   = value[3:0];
            default: ;
        endcase
        cfg_writes++;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_regs(input logic [63:0] pat, input int plen,
                                input logic [63:0] rep, input int rlen);
        cfg_write(sfr_pkg::CFG_PATTERN_BYTES, pat);
        cfg_write(sfr_pkg::CFG_PATTERN_LENGTH, 64'(plen));
        cfg_write(sfr_pkg::CFG_REPLACEMENT_BYTES, rep);
        cfg_write(sfr_pkg::CFG_REPLACEMENT_LENGTH, 64'(rlen));
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eos);
        int gap;
        gap = tx_stall ? $urandom_range(0, 6) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eos;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_edit(b, eos);
        items_sent++;
    endtask

    task automatic send_text(input string text, input bit eos_at_end);
        int i;
        for (i = 0; i < text.len(); i++)
            send_byte(text[i], eos_at_end && i == text.len() - 1);
    endtask

    // stop offering and let every expected result drain
    task automatic settle();
        s_tvalid <= 1'b0;
        while (edits_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic test_reset_values();
        // reset pattern is a single zero byte with an empty replacement
        send_byte(8'h00, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h00, 1'b1);
        settle();
    endtask

    task automatic test_basic_replace();
        program_regs(64'h636261, 3, 64'h5958, 2);
        send_text("aabcab\n", 1'b0);
        settle();
    endtask

    task automatic test_pattern_swap_while_held();
        program_regs(64'h71626178, 4, 64'h5A5A, 2);
        send_text("xab", 1'b0);
        settle();
        // held bytes are tested against the new pattern
        cfg_write(sfr_pkg::CFG_PATTERN_BYTES, 64'h636261);
        cfg_write(sfr_pkg::CFG_PATTERN_LENGTH, 64'd3);
        send_byte(8'h63, 1'b0);
        send_byte(8'h64, 1'b1);
        settle();
    endtask

    task automatic test_extremes();
        int i;
        // out of range lengths clamp to eight
        program_regs('1, 15, 64'h0123456789ABCDEF, 15);
        for (i = 0; i < 8; i++)
            send_byte(8'hFF, i == 7);
        settle();
        // zero pattern length acts as one, newline pattern never matches
        program_regs(64'h0A, 0, 64'h41, 1);
        send_byte(sfr_pkg::NEWLINE_BYTE, 1'b0);
        settle();
    endtask

    task automatic test_output_stall();
        int i;
        program_regs(64'h6261, 2, 64'h3837363534333231, 8);
        tx_stall = 1'b0;
        hold_req = 250;
        for (i = 0; i < 30; i++)
            send_byte((i % 2 == 0) ? 8'h61 : 8'h62, i == 29);
        tx_stall = 1'b1;
        settle();
    endtask

    task automatic random_text(input int count);
        int k;
        int j;
        int sel;
        int plen;
        int part;
        k    = 0;
        plen = eff_plen();
        while (k < count)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 35)
            begin
                for (j = 0; j < plen; j++)
                    send_byte(pat_bytes[8*j +: 8], $urandom_range(0, 29) == 0);
                k += plen;
            end
            else if (sel < 55 && plen > 1)
            begin
                part = $urandom_range(1, plen - 1);
                for (j = 0; j < part; j++)
                    send_byte(pat_bytes[8*j +: 8], 1'b0);
                send_byte(pat_bytes[8*$urandom_range(0, plen - 1) +: 8],
                          $urandom_range(0, 29) == 0);
                k += part + 1;
            end
            else if (sel < 62)
            begin
                send_byte(sfr_pkg::NEWLINE_BYTE, $urandom_range(0, 9) == 0);
                k++;
            end
            else if (sel < 85)
            begin
                send_byte(pat_bytes[8*$urandom_range(0, plen - 1) +: 8],
                          $urandom_range(0, 29) == 0);
                k++;
            end
            else
            begin
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
                k++;
            end
        end
    endtask

    task automatic test_random_phases();
        int          p;
        int          j;
        logic [63:0] pat;
        int          plen;
        int          rlen;
        for (p = 0; p < PHASES; p++)
        begin
            if ($urandom_range(0, 3) == 0)
                pat = {$urandom, $urandom};
            else
                for (j = 0; j < 8; j++)
                    pat[8*j +: 8] = ($urandom_range(0, 11) == 0) ? sfr_pkg::NEWLINE_BYTE
                                  : 8'h61 + 8'($urandom_range(0, 2));
            case (p)
                0:       plen = 8;
                1:       plen = 1;
                default:
                begin
                    j = $urandom_range(0, 9);
                    plen = (j == 0) ? 0 : (j == 1) ? int'($urandom_range(9, 15))
                         : int'($urandom_range(1, 8));
                end
            endcase
            rlen = (p == 0) ? 8 : (p == 1) ? 0 : int'($urandom_range(0, 10));
            program_regs(pat, plen, {$urandom, $urandom}, rlen);
            tx_stall = $urandom_range(0, 3) != 0;
            rx_stall = $urandom_range(0, 3) != 0;
            random_text(PHASE_ITEMS);
            settle();
        end
        tx_stall = 1'b1;
        rx_stall = 1'b1;
    endtask

    // receiver: random gaps per result, plus a long hold on request
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (m_tvalid && m_tready)
                gap_left = rx_stall ? $urandom_range(0, 6) : 0;
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{m_tdata, m_tuser[0], m_tlast, m_tuser[1]};
            results_seen++;
            if (edits_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result byte %h valid %b last %b done %b",
                         $time, got.data, got.valid, got.last, got.done);
            end
            else
            begin
                want = edits_due.pop_front();
                if (got !== want)
                begin
                    errors++;
                    $display("%0t: expected %h %b%b%b actual %h %b%b%b (byte valid last done)",
                             $time, want.data, want.valid, want.last, want.done,
                             got.data, got.valid, got.last, got.done);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, edits_due.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_basic_replace();
        test_pattern_swap_while_held();
        test_extremes();
        test_output_stall();
        test_random_phases();
        settle();
        $display("sent %0d text bytes under %0d register writes, checked %0d results",
                 items_sent, cfg_writes, results_seen);
        $display("covered replace, delete, newline and end flushes, clamped lengths, stalls");
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/sfr_pkg.sv
hw/rtl/sfr_front.sv
hw/rtl/sfr_fifo.sv
hw/rtl/sfr_back.sv
hw/rtl/stream_find_and_replace.sv
dv/stream_find_and_replace_tb.sv
